// ----- rtl/bda_pkg.sv -----
package bda_pkg;

  // fixed field widths
  localparam int LEVEL_W  = 5;
  localparam int BUTTON_W = 3;
  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // register reset values
  localparam logic [COUNT_W-1:0]  DEBOUNCE_RST    = 16'd20;
  localparam logic [COUNT_W-1:0]  HOLD_DELAY_RST  = 16'd200;
  localparam logic [COUNT_W-1:0]  REPEAT_RST      = 16'd60;
  localparam logic [LEVEL_W-1:0]  REPEAT_MASK_RST = 5'd6;
  localparam logic [COUNT_W-1:0]  COUNT_SAT       = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE    = 2'd0,
    REG_HOLD_DELAY  = 2'd1,
    REG_REPEAT      = 2'd2,
    REG_REPEAT_MASK = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] debounce_ms;
    logic [COUNT_W-1:0] hold_delay_ms;
    logic [COUNT_W-1:0] repeat_ms;
    logic [LEVEL_W-1:0] repeat_mask;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [BUTTON_W-1:0] button;
    logic                is_repeat;
  } evt_t;

  // saturating increment of a tick counter
  function automatic logic [COUNT_W-1:0] inc_sat(input logic [COUNT_W-1:0] v);
    inc_sat = (v == COUNT_SAT) ? COUNT_SAT : v + 1'b1;
  endfunction

endpackage

// ----- rtl/bda_in_if.sv -----
interface bda_in_if
  import bda_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface

// ----- rtl/bda_out_if.sv -----
interface bda_out_if
  import bda_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [BUTTON_W-1:0] button;
  logic                is_repeat;

  modport source (output valid, output button, output is_repeat, input ready);
  modport sink   (input valid, input button, input is_repeat, output ready);
endinterface

// ----- rtl/bda_cfg_regs.sv -----
module bda_cfg_regs
  import bda_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // register file, to be written only while the block is idle; the user must ensure this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.hold_delay_ms <= HOLD_DELAY_RST;
      cfg_r.repeat_ms     <= REPEAT_RST;
      cfg_r.repeat_mask   <= REPEAT_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        REG_DEBOUNCE:    cfg_r.debounce_ms   <= cfg_wdata;
        REG_HOLD_DELAY:  cfg_r.hold_delay_ms <= cfg_wdata;
        REG_REPEAT:      cfg_r.repeat_ms     <= cfg_wdata;
        REG_REPEAT_MASK: cfg_r.repeat_mask   <= cfg_wdata[LEVEL_W-1:0];
        default:         cfg_r.repeat_mask   <= cfg_r.repeat_mask;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/bda_step.sv -----
module bda_step
  import bda_pkg::*;
#(
  parameter int NUM_BUTTONS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [LEVEL_W-1:0] levels_in,
  input  cfg_t               cfg,
  output evt_t               evt
);

  localparam logic [LEVEL_W-1:0] BTN_MASK = LEVEL_W'(((1 << NUM_BUTTONS) - 1) & 31);

  logic [LEVEL_W-1:0]  prev_levels_r, prev_levels_nxt;
  logic                deb_active_r, deb_active_nxt;
  logic [COUNT_W-1:0]  deb_count_r, deb_count_nxt;
  logic [BUTTON_W-1:0] pending_r, pending_nxt;
  logic                hold_valid_r, hold_valid_nxt;
  logic [BUTTON_W-1:0] held_r, held_nxt;
  logic [COUNT_W-1:0]  held_time_r, held_time_nxt;
  logic [COUNT_W-1:0]  since_rep_r, since_rep_nxt;

  logic [LEVEL_W-1:0]  levels;
  logic [7:0]          levels8;
  logic [7:0]          mask8;
  logic [LEVEL_W-1:0]  edges;
  logic [BUTTON_W-1:0] top_edge;
  logic [COUNT_W-1:0]  deb_inc;
  logic [COUNT_W-1:0]  ht_inc;
  logic                pressed;

  assign levels  = levels_in & BTN_MASK;
  assign levels8 = {3'b000, levels};
  assign mask8   = {3'b000, cfg.repeat_mask};
  assign edges   = prev_levels_r & ~levels & BTN_MASK;
  assign deb_inc = inc_sat(deb_count_r);
  assign ht_inc  = inc_sat(held_time_r);

  // highest-numbered falling edge wins
  always_comb begin
    top_edge = '0;
    for (int i = 0; i < LEVEL_W; i++) begin
      if (edges[i]) begin
        top_edge = BUTTON_W'(i);
      end
    end
  end

  // next state and event for one tick
  always_comb begin
    prev_levels_nxt = levels;
    deb_active_nxt  = deb_active_r;
    deb_count_nxt   = deb_count_r;
    pending_nxt     = pending_r;
    hold_valid_nxt  = hold_valid_r;
    held_nxt        = held_r;
    held_time_nxt   = held_time_r;
    since_rep_nxt   = inc_sat(since_rep_r);
    pressed         = 1'b0;
    evt             = '0;

    // debounce window
    if (deb_active_r) begin
      deb_count_nxt = deb_inc;
      if (deb_inc >= cfg.debounce_ms) begin
        deb_active_nxt = 1'b0;
        if (!levels8[pending_r]) begin
          pressed        = 1'b1;
          hold_valid_nxt = 1'b1;
          held_nxt       = pending_r;
          held_time_nxt  = '0;
          evt.valid      = 1'b1;
          evt.button     = pending_r;
          evt.is_repeat  = 1'b0;
        end
      end
    end else if (edges != '0) begin
      pending_nxt    = top_edge;
      deb_active_nxt = 1'b1;
      deb_count_nxt  = '0;
    end

    // hold tracking and auto repeat
    if (hold_valid_r && !pressed) begin
      if (levels8[held_r]) begin
        hold_valid_nxt = 1'b0;
      end else begin
        held_time_nxt = ht_inc;
        if (mask8[held_r] && ht_inc >= cfg.hold_delay_ms &&
            since_rep_nxt >= cfg.repeat_ms) begin
          since_rep_nxt = '0;
          evt.valid     = 1'b1;
          evt.button    = held_r;
          evt.is_repeat = 1'b1;
        end
      end
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_levels_r <= BTN_MASK;
      deb_active_r  <= 1'b0;
      deb_count_r   <= '0;
      pending_r     <= '0;
      hold_valid_r  <= 1'b0;
      held_r        <= '0;
      held_time_r   <= '0;
      since_rep_r   <= COUNT_SAT;
    end else if (step_en) begin
      prev_levels_r <= prev_levels_nxt;
      deb_active_r  <= deb_active_nxt;
      deb_count_r   <= deb_count_nxt;
      pending_r     <= pending_nxt;
      hold_valid_r  <= hold_valid_nxt;
      held_r        <= held_nxt;
      held_time_r   <= held_time_nxt;
      since_rep_r   <= since_rep_nxt;
    end
  end

endmodule

// ----- rtl/button_debounce_autorepeat_unit.sv -----
// Button debounce with auto repeat. Each input word is one 1 ms tick carrying
// the active-low levels of the buttons; each output word is a button code with
// is_repeat clear for a confirmed press and set for an auto repeat event. A
// tick produces at most one word. The block takes one tick per clock cycle when
// the result register is free or being drained; a tick waits in the input
// register until then and its result is loaded into the result register, from
// which the word is offered. A new tick can enter the input register while an earlier
// result still waits. Registers: 0 debounce window, 1 hold delay before
// repeats, 2 repeat interval (all in ticks) and 3 repeat mask; write them only
// while the block is idle.
module button_debounce_autorepeat_unit
  import bda_pkg::*;
#(
  parameter int NUM_BUTTONS = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bda_in_if.sink               in_if,
  bda_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg;
  evt_t evt;

  logic                s1_valid_r;
  logic [LEVEL_W-1:0]  s1_levels_r;
  logic                s1_adv;
  logic                out_valid_r;
  logic [BUTTON_W-1:0] out_button_r;
  logic                out_rep_r;

  bda_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // tick advances when the result register is free or being drained
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_levels_r <= in_if.button_levels;
    end
  end

  bda_step #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (s1_adv),
    .levels_in (s1_levels_r),
    .cfg       (cfg),
    .evt       (evt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= evt.valid;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && evt.valid) begin
      out_button_r <= evt.button;
      out_rep_r    <= evt.is_repeat;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.button    = out_button_r;
  assign out_if.is_repeat = out_rep_r;

endmodule

// ----- verif/bda_event_checker.sv -----
module bda_event_checker
  import bda_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bda_in_if                    in_mon,
  bda_out_if                   out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_total,
  output int                   pending_words,
  output int                   presses_seen,
  output int                   repeats_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [BUTTON_W-1:0] button;
    logic                is_repeat;
  } button_evt_t;

  // events predicted but not yet seen on the result channel
  button_evt_t due_events[$];
  button_evt_t oldest;

  // register copies
  logic [COUNT_W-1:0] win_len;
  logic [COUNT_W-1:0] hold_dly;
  logic [COUNT_W-1:0] rpt_gap;
  logic [LEVEL_W-1:0] rpt_mask;

  // tracked button state
  logic [LEVEL_W-1:0]  prev_lv;
  logic                window_on;
  logic [COUNT_W-1:0]  window_cnt;
  logic [BUTTON_W-1:0] window_btn;
  logic                holding;
  logic [BUTTON_W-1:0] hold_btn;
  logic [COUNT_W-1:0]  hold_cnt;
  logic [COUNT_W-1:0]  gap_cnt;

  // counters start at zero
  int errors;
  int n_press;
  int n_repeat;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 16'd1;
  endfunction

  // one tick of debounce and auto repeat tracking
  task automatic advance_tick(input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W-1:0] falls;
    logic               got_press;
    falls = prev_lv & ~lv;
    got_press = 1'b0;
    gap_cnt = bump(gap_cnt);

    // window running: edges are ignored until it closes
    if (window_on) begin
      window_cnt = bump(window_cnt);
      if (window_cnt >= win_len) begin
        window_on = 1'b0;
        if (!lv[window_btn]) begin
          got_press = 1'b1;
          holding = 1'b1;
          hold_btn = window_btn;
          hold_cnt = '0;
          due_events.push_back('{button: window_btn, is_repeat: 1'b0});
        end
      end
    end else if (falls != '0) begin
      // highest falling button takes the window
      for (int i = 0; i < LEVEL_W; i++) begin
        if (falls[i]) window_btn = BUTTON_W'(i);
      end
      window_on = 1'b1;
      window_cnt = '0;
    end

    // hold tracking, a press in this tick wins over a repeat
    if (holding && !got_press) begin
      if (lv[hold_btn]) begin
        holding = 1'b0;
      end else begin
        hold_cnt = bump(hold_cnt);
        if (rpt_mask[hold_btn] && hold_cnt >= hold_dly && gap_cnt >= rpt_gap) begin
          gap_cnt = '0;
          due_events.push_back('{button: hold_btn, is_repeat: 1'b1});
        end
      end
    end
    prev_lv = lv;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win_len = DEBOUNCE_RST;
      hold_dly = HOLD_DELAY_RST;
      rpt_gap = REPEAT_RST;
      rpt_mask = REPEAT_MASK_RST;
      prev_lv = '1;
      window_on = 1'b0;
      window_cnt = '0;
      window_btn = '0;
      holding = 1'b0;
      hold_btn = '0;
      hold_cnt = '0;
      gap_cnt = COUNT_SAT;
      due_events.delete();
    end else begin
      // result words are checked before this edge's tick is predicted
      if (out_mon.valid && out_mon.ready) begin
        if (due_events.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected word button=%0d is_repeat=%0b", $realtime,
                     out_mon.button, out_mon.is_repeat);
          errors++;
        end else begin
          oldest = due_events.pop_front();
          if (out_mon.button !== oldest.button || out_mon.is_repeat !== oldest.is_repeat) begin
            if (errors < 10)
              $display({"%0t: mismatch expected button=%0d is_repeat=%0b,",
                        " got button=%0d is_repeat=%0b"},
                       $realtime, oldest.button, oldest.is_repeat,
                       out_mon.button, out_mon.is_repeat);
            errors++;
          end else if (oldest.is_repeat) begin
            n_repeat++;
          end else begin
            n_press++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) advance_tick(in_mon.button_levels);

      // register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          REG_DEBOUNCE:    win_len = cfg_wdata;
          REG_HOLD_DELAY:  hold_dly = cfg_wdata;
          REG_REPEAT:      rpt_gap = cfg_wdata;
          REG_REPEAT_MASK: rpt_mask = cfg_wdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
    fail_total <= errors;
    pending_words <= due_events.size();
    presses_seen <= n_press;
    repeats_seen <= n_repeat;
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import bda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  int fail_total;
  int pending_words;
  int presses_seen;
  int repeats_seen;

  int  ticks_sent;
  int  settings_used;
  bit  steady_in;
  int  cur_win;
  int  cur_hold;
  int  cur_rpt;

  // opening ticks with every window and repeat length at zero
  logic [LEVEL_W-1:0] opening_ticks [14] = '{
    5'b11111, 5'b01111, 5'b01111, 5'b01111, 5'b01111, 5'b11111, 5'b00000,
    5'b00000, 5'b11111, 5'b10110, 5'b10100, 5'b11111, 5'b11110, 5'b11111
  };
  // short window: an edge inside it, then a held repeating button
  logic [LEVEL_W-1:0] window_ticks [11] = '{
    5'b11101, 5'b11100, 5'b11100, 5'b11101, 5'b11101, 5'b11101, 5'b11101,
    5'b11101, 5'b11101, 5'b11101, 5'b11111
  };

  bda_in_if  in_ch ();
  bda_out_if out_ch ();

  button_debounce_autorepeat_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  bda_event_checker event_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_total    (fail_total),
    .pending_words (pending_words),
    .presses_seen  (presses_seen),
    .repeats_seen  (repeats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // send one tick word, with a random gap unless in a steady stretch
  task automatic send_tick(input logic [LEVEL_W-1:0] lv);
    int gap;
    gap = 0;
    if (!steady_in) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(5, 30);
      else if ($urandom_range(0, 2) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.button_levels <= lv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // stop sending and wait for every predicted word plus pipeline slack
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input int d, input int h, input int r, input int m);
    cfg_we <= 1'b1;
    cfg_idx <= REG_DEBOUNCE;
    cfg_wdata <= CFG_W'(d);
    @(posedge clk);
    cfg_idx <= REG_HOLD_DELAY;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_idx <= REG_REPEAT;
    cfg_wdata <= CFG_W'(r);
    @(posedge clk);
    cfg_idx <= REG_REPEAT_MASK;
    cfg_wdata <= CFG_W'(m);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_win = d;
    cur_hold = h;
    cur_rpt = r;
    settings_used++;
  endtask

  // one burst: mostly a clean press and hold, sometimes noise
  task automatic play_burst();
    int kind;
    int b;
    int span;
    logic [LEVEL_W-1:0] rest;
    logic [LEVEL_W-1:0] lv;
    kind = $urandom_range(0, 9);
    steady_in = ($urandom_range(0, 3) == 0);
    if (kind <= 6) begin
      b = $urandom_range(0, LEVEL_W - 1);
      rest = ($urandom_range(0, 4) == 0) ? LEVEL_W'($urandom_range(0, 31)) : '1;
      rest[b] = 1'b1;
      send_tick(rest);
      // contact bounce before the level settles
      repeat ($urandom_range(0, 2)) begin
        lv = rest;
        lv[b] = 1'($urandom_range(0, 1));
        send_tick(lv);
      end
      span = cur_win + cur_hold + 3 * cur_rpt + 4;
      if (span > 420) span = 420;
      repeat ($urandom_range(1, span)) begin
        lv = rest;
        lv[b] = 1'b0;
        if ($urandom_range(0, 15) == 0) lv = lv & LEVEL_W'($urandom_range(0, 31));
        send_tick(lv);
      end
      repeat ($urandom_range(1, 3)) send_tick(rest);
    end else if (kind <= 8) begin
      repeat ($urandom_range(1, 8)) send_tick(LEVEL_W'($urandom_range(0, 31)));
    end else begin
      send_tick('1);
      send_tick(LEVEL_W'($urandom_range(0, 31)));
    end
  endtask

  task automatic run_phase(input int d, input int h, input int r, input int m,
                           input int budget);
    int start;
    settle();
    load_settings(d, h, r, m);
    start = ticks_sent;
    while (ticks_sent - start < budget) play_burst();
  endtask

  // result side back-pressure: free runs, random stalls, a few long stalls
  initial begin
    int run_len;
    int mode;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run_len = $urandom_range(5, 60);
      mode = $urandom_range(0, 3);
      repeat (run_len) begin
        @(posedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          3: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      if ($urandom_range(0, 7) == 0) begin
        @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    ticks_sent = 0;
    settings_used = 0;
    steady_in = 1'b1;
    cur_win = 0;
    cur_hold = 0;
    cur_rpt = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.button_levels <= '1;
    cfg_we <= 1'b0;
    cfg_idx <= REG_DEBOUNCE;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    load_settings(0, 0, 0, 31);
    foreach (opening_ticks[i]) send_tick(opening_ticks[i]);
    settle();
    load_settings(2, 3, 2, 5'b00010);
    foreach (window_ticks[i]) send_tick(window_ticks[i]);

    // random part over several settings, extremes among them
    run_phase(DEBOUNCE_RST, HOLD_DELAY_RST, REPEAT_RST, REPEAT_MASK_RST, 300);
    run_phase(65535, 65535, 65535, 0, 40);
    run_phase(1, 65535, 1, 31, 60);
    repeat (5) begin
      run_phase($urandom_range(0, 6), $urandom_range(0, 12), $urandom_range(0, 8),
                $urandom_range(0, 31), 160);
    end
    settle();

    $display("covered %0d ticks under %0d register settings", ticks_sent, settings_used);
    $display("checked %0d confirmed presses and %0d auto repeats",
             presses_seen, repeats_seen);
    if (fail_total == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
